@@ rtl/core/polyphonic_decaying_tone_synth_defines.svh @@
// Assertion macros shared by the tone synthesizer RTL.
`ifndef POLYPHONIC_DECAYING_TONE_SYNTH_DEFINES_SVH
`define POLYPHONIC_DECAYING_TONE_SYNTH_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked while reset is released
`define PDTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// Next-cycle implication, checked while reset is released
`define PDTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define PDTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PDTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/pdts_pkg.sv @@
// Types, constants and table functions of the polyphonic tone synthesizer.
package pdts_pkg;

    // Default sizes
    localparam int VOICE_COUNT_DEF      = 13;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int PHASE_BITS_DEF       = 24;

    // Field widths
    localparam int GAIN_W   = 31;
    localparam int PERIOD_W = 20;
    localparam int BASE_W   = 24;
    localparam int DECAY_W  = 16;
    localparam int AMP_W    = 16;
    localparam int SINE_W   = 15;
    localparam int RATIO_W  = 17;
    localparam int MUL_A_W  = 31;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SAMPLE_W = 32;

    // Register reset values
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 31'd134217727;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd16000;
    localparam logic [BASE_W-1:0]   BASE_RST   = 24'd548692;
    localparam logic [DECAY_W-1:0]  DECAY_RST  = 16'd65529;

    localparam logic [AMP_W-1:0] AMP_FULL = 16'hFFFF;

    // Register indexes (word address)
    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_BASE   = 2'd2;
    localparam logic [1:0] REG_DECAY  = 2'd3;

    // Transaction modes
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Scan codes of the chromatic keys
    localparam logic [7:0] KEY_C    = 8'h10;
    localparam logic [7:0] KEY_CS   = 8'h03;
    localparam logic [7:0] KEY_D    = 8'h11;
    localparam logic [7:0] KEY_DS   = 8'h04;
    localparam logic [7:0] KEY_E    = 8'h12;
    localparam logic [7:0] KEY_F    = 8'h13;
    localparam logic [7:0] KEY_FS   = 8'h06;
    localparam logic [7:0] KEY_G    = 8'h14;
    localparam logic [7:0] KEY_GS   = 8'h07;
    localparam logic [7:0] KEY_A    = 8'h15;
    localparam logic [7:0] KEY_AS   = 8'h08;
    localparam logic [7:0] KEY_B    = 8'h16;
    localparam logic [7:0] KEY_C_HI = 8'h17;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_TERM,
        ST_DECAY,
        ST_INC,
        ST_PHASE,
        ST_OUT
    } pdts_state_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] voice;
    } pdts_key_t;

    // Scan code to semitone voice
    function automatic pdts_key_t key_to_voice(input logic [7:0] code);
        pdts_key_t k;
        k.hit = 1'b1;
        case (code)
            KEY_C:    k.voice = 5'd0;
            KEY_CS:   k.voice = 5'd1;
            KEY_D:    k.voice = 5'd2;
            KEY_DS:   k.voice = 5'd3;
            KEY_E:    k.voice = 5'd4;
            KEY_F:    k.voice = 5'd5;
            KEY_FS:   k.voice = 5'd6;
            KEY_G:    k.voice = 5'd7;
            KEY_GS:   k.voice = 5'd8;
            KEY_A:    k.voice = 5'd9;
            KEY_AS:   k.voice = 5'd10;
            KEY_B:    k.voice = 5'd11;
            KEY_C_HI: k.voice = 5'd12;
            default: begin
                k.hit   = 1'b0;
                k.voice = 5'd0;
            end
        endcase
        return k;
    endfunction

    // round(65536 * 2^(k/12))
    function automatic logic [RATIO_W-1:0] semitone_ratio(input logic [3:0] semi);
        logic [RATIO_W-1:0] r;
        case (semi)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd69433;
            4'd2:    r = 17'd73562;
            4'd3:    r = 17'd77936;
            4'd4:    r = 17'd82570;
            4'd5:    r = 17'd87480;
            4'd6:    r = 17'd92682;
            4'd7:    r = 17'd98193;
            4'd8:    r = 17'd104032;
            4'd9:    r = 17'd110218;
            4'd10:   r = 17'd116772;
            4'd11:   r = 17'd123715;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // Sine magnitude (Q15) at pos/depth of a quarter turn; elaboration only.
    // Taylor series to the 11th power in Q30, rounded half up.
    function automatic logic [SINE_W-1:0] sine_mag(input int unsigned pos,
                                                   input int unsigned depth_log2);
        longint unsigned ang;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned s;
        longint unsigned q15;
        ang  = (longint'(pos) * HALF_PI_Q30 + (64'd1 << (depth_log2 - 1))) >> depth_log2;
        t2   = (ang * ang) >> 30;
        term = ang;
        s    = ang;
        term = ((term * t2) >> 30) / 6;
        s    = s - term;
        term = ((term * t2) >> 30) / 20;
        s    = s + term;
        term = ((term * t2) >> 30) / 42;
        s    = s - term;
        term = ((term * t2) >> 30) / 72;
        s    = s + term;
        term = ((term * t2) >> 30) / 110;
        s    = s - term;
        q15  = (s + 64'd16384) >> 15;
        if (q15 > 64'd32767) begin
            q15 = 64'd32767;
        end
        return q15[SINE_W-1:0];
    endfunction

endpackage

@@ rtl/core/polyphonic_decaying_tone_synth.sv @@
// Polyphonic decaying tone synthesizer: key events, sample ticks, shared multiplier.
//
// Input channel (s_*): one transaction is a key event (s_mode = 0) or a sample
// tick (s_mode = 1). A key press sets its semitone voice to full amplitude, a
// release silences it; unmapped scan codes are ignored. A key event returns
// nothing.
// Result channel (m_*): each tick returns one saturated signed 32-bit sample.
// A tick walks the voices through one shared 31x17 multiplier, one voice at a
// time in the steps gain, sine term, decay, increment and phase write, then
// loads the output register in a final step, with the sample visible on m_*
// the cycle after the load. s_ready is low while busy.
// The output register holds one sample; a stalled receiver lets the block
// accept more key events, but a following tick waits in its final step until
// the previous sample is taken.
// Configuration: APB registers at byte 0 (gain), 4 (period), 8 (base
// increment), 12 (decay); write only while the block is idle. pready is high.
// Reset (aresetn low, synchronous): registers to defaults, voices silent,
// phases and the sample counter zero, no sample pending.
module polyphonic_decaying_tone_synth #(
    parameter int VOICE_COUNT      = pdts_pkg::VOICE_COUNT_DEF,
    parameter int SINE_TABLE_DEPTH = pdts_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int PHASE_BITS       = pdts_pkg::PHASE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_key_code,
    input  logic        s_key_pressed,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_audio_sample,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "polyphonic_decaying_tone_synth_defines.svh"

    localparam int VW      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int QW      = IDX_W - 2;
    localparam int QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int SUM_W   = 33 + $clog2(VOICE_COUNT);
    localparam int PW      = pdts_pkg::PROD_W;

    localparam logic [pdts_pkg::SINE_W-1:0] SINE_PEAK =
        pdts_pkg::sine_mag(SINE_TABLE_DEPTH, IDX_W);
    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

    // Configuration registers
    logic [pdts_pkg::GAIN_W-1:0]   gain_reg;
    logic [pdts_pkg::PERIOD_W-1:0] period_reg;
    logic [pdts_pkg::BASE_W-1:0]   base_reg;
    logic [pdts_pkg::DECAY_W-1:0]  decay_reg;

    // Voice state
    logic [pdts_pkg::AMP_W-1:0] amp_reg   [VOICE_COUNT];
    logic [PHASE_BITS-1:0]      phase_reg [VOICE_COUNT];
    logic [pdts_pkg::PERIOD_W-1:0] count_reg;

    // Sequencer
    pdts_pkg::pdts_state_t state_reg, state_next;
    logic [VW-1:0]  vidx_reg;
    logic [3:0]     semi_reg;
    logic [1:0]     oct_reg;
    logic           wrap_reg;
    logic           last_voice;

    // Datapath
    logic [PW-1:0]                prod_reg;
    logic [pdts_pkg::MUL_A_W-1:0] mul_a;
    logic [pdts_pkg::MUL_B_W-1:0] mul_b;
    logic [pdts_pkg::SINE_W-1:0]  mag_reg;
    logic                         neg_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [31:0]           out_reg;
    logic                         out_valid_reg;

    logic s_ready_int;
    logic cfg_wr;
    logic tick_acc;
    logic key_acc;
    logic out_load;

    // Quarter-wave sine table, built at elaboration
    logic [pdts_pkg::SINE_W-1:0] quarter_rom [QUARTER];
    for (genvar g = 0; g < QUARTER; g++) begin : g_rom
        assign quarter_rom[g] = pdts_pkg::sine_mag(32'(g) * 4, IDX_W);
    end

    // Table address from the current voice phase
    logic [IDX_W-1:0] sine_idx;
    logic [QW-1:0]    sine_rem;
    logic [QW-1:0]    sine_addr;
    logic             sine_peak;
    assign sine_idx  = phase_reg[vidx_reg][PHASE_BITS-1 -: IDX_W];
    assign sine_rem  = sine_idx[QW-1:0];
    assign sine_addr = sine_idx[IDX_W-2] ? (QW'(0) - sine_rem) : sine_rem;
    assign sine_peak = sine_idx[IDX_W-2] && (sine_rem == '0);

    // Key decode
    pdts_pkg::pdts_key_t key_info;
    logic                key_hit;
    assign key_info = pdts_pkg::key_to_voice(s_key_code);
    assign key_hit  = key_info.hit && (32'(key_info.voice) < VOICE_COUNT);

    assign tick_acc   = s_valid && s_ready_int && (s_mode == pdts_pkg::MODE_TICK);
    assign key_acc    = s_valid && s_ready_int && (s_mode == pdts_pkg::MODE_KEY);
    assign last_voice = (32'(vidx_reg) == VOICE_COUNT - 1);
    assign out_load   = (state_reg == pdts_pkg::ST_OUT) && (!out_valid_reg || m_ready);
    assign cfg_wr     = psel && penable && pwrite;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pdts_pkg::ST_IDLE:  if (tick_acc) state_next = pdts_pkg::ST_GAIN;
            pdts_pkg::ST_GAIN:  state_next = pdts_pkg::ST_TERM;
            pdts_pkg::ST_TERM:  state_next = pdts_pkg::ST_DECAY;
            pdts_pkg::ST_DECAY: state_next = pdts_pkg::ST_INC;
            pdts_pkg::ST_INC:   state_next = pdts_pkg::ST_PHASE;
            pdts_pkg::ST_PHASE: begin
                state_next = last_voice ? pdts_pkg::ST_OUT : pdts_pkg::ST_GAIN;
            end
            pdts_pkg::ST_OUT:   if (out_load) state_next = pdts_pkg::ST_IDLE;
            default:            state_next = pdts_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: ready and multiplier operands
    always_comb begin
        s_ready_int = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        case (state_reg)
            pdts_pkg::ST_IDLE: s_ready_int = 1'b1;
            pdts_pkg::ST_GAIN: begin
                mul_a = gain_reg;
                mul_b = {1'b0, amp_reg[vidx_reg]};
            end
            pdts_pkg::ST_TERM: begin
                mul_a = prod_reg[46:16];
                mul_b = {2'b00, mag_reg};
            end
            pdts_pkg::ST_DECAY: begin
                mul_a = {15'd0, amp_reg[vidx_reg]};
                mul_b = {1'b0, decay_reg};
            end
            pdts_pkg::ST_INC: begin
                mul_a = {7'd0, base_reg};
                mul_b = pdts_pkg::semitone_ratio(semi_reg);
            end
            default: begin
                s_ready_int = 1'b0;
            end
        endcase
    end

    // Phase step from the ratio product, octave shifted
    logic [PW+1:0]         inc_shifted;
    logic [PHASE_BITS-1:0] inc_val;
    assign inc_shifted = {2'b00, prod_reg} << oct_reg;
    assign inc_val     = PHASE_BITS'(inc_shifted >> 16);

    // Sine term magnitude
    logic [30:0] term_mag;
    assign term_mag = prod_reg[45:15];

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdts_pkg::ST_IDLE;
            vidx_reg  <= '0;
            semi_reg  <= '0;
            oct_reg   <= '0;
            wrap_reg  <= 1'b0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (tick_acc) begin
                vidx_reg <= '0;
                semi_reg <= '0;
                oct_reg  <= '0;
                // counter + 1 reaching the period (zero acts as one)
                wrap_reg <= ({1'b0, count_reg} + 21'd1) >=
                            ((period_reg == '0) ? 21'd1 : {1'b0, period_reg});
            end else if (state_reg == pdts_pkg::ST_PHASE && !last_voice) begin
                vidx_reg <= vidx_reg + VW'(1);
                if (semi_reg == 4'd11) begin
                    semi_reg <= '0;
                    oct_reg  <= oct_reg + 2'd1;
                end else begin
                    semi_reg <= semi_reg + 4'd1;
                end
            end
            // a new sample keeps valid high even when the old one leaves
            if (out_load) begin
                out_valid_reg <= 1'b1;
                count_reg     <= wrap_reg ? '0 : count_reg + 20'd1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Voice state: key writes while idle, decay and phase updates per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < VOICE_COUNT; v++) begin
                amp_reg[v]   <= '0;
                phase_reg[v] <= '0;
            end
        end else begin
            if (key_acc && key_hit) begin
                amp_reg[key_info.voice[VW-1:0]] <= s_key_pressed ? pdts_pkg::AMP_FULL : '0;
            end
            if (state_reg == pdts_pkg::ST_INC) begin
                amp_reg[vidx_reg] <= prod_reg[31:16];
            end
            if (state_reg == pdts_pkg::ST_PHASE) begin
                phase_reg[vidx_reg] <= wrap_reg ? '0 : phase_reg[vidx_reg] + inc_val;
            end
        end
    end

    // Shared multiplier, table read and accumulator
    always_ff @(posedge aclk) begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
        if (state_reg == pdts_pkg::ST_GAIN) begin
            mag_reg <= sine_peak ? SINE_PEAK : quarter_rom[sine_addr];
            neg_reg <= sine_idx[IDX_W-1];
        end
        if (tick_acc) begin
            sum_reg <= '0;
        end else if (state_reg == pdts_pkg::ST_DECAY) begin
            sum_reg <= neg_reg ? sum_reg - SUM_W'(term_mag) : sum_reg + SUM_W'(term_mag);
        end
        if (out_load) begin
            if (sum_reg > SAT_HI) begin
                out_reg <= 32'sh7FFFFFFF;
            end else if (sum_reg < SAT_LO) begin
                out_reg <= 32'sh80000000;
            end else begin
                out_reg <= sum_reg[31:0];
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= pdts_pkg::GAIN_RST;
            period_reg <= pdts_pkg::PERIOD_RST;
            base_reg   <= pdts_pkg::BASE_RST;
            decay_reg  <= pdts_pkg::DECAY_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pdts_pkg::REG_GAIN:   gain_reg   <= pwdata[pdts_pkg::GAIN_W-1:0];
                pdts_pkg::REG_PERIOD: period_reg <= pwdata[pdts_pkg::PERIOD_W-1:0];
                pdts_pkg::REG_BASE:   base_reg   <= pwdata[pdts_pkg::BASE_W-1:0];
                pdts_pkg::REG_DECAY:  decay_reg  <= pwdata[pdts_pkg::DECAY_W-1:0];
                default:              gain_reg   <= gain_reg;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[3:2])
            pdts_pkg::REG_GAIN:   prdata = {1'b0, gain_reg};
            pdts_pkg::REG_PERIOD: prdata = {12'd0, period_reg};
            pdts_pkg::REG_BASE:   prdata = {8'd0, base_reg};
            pdts_pkg::REG_DECAY:  prdata = {16'd0, decay_reg};
            default:              prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign s_ready        = s_ready_int;
    assign m_valid        = out_valid_reg;
    assign m_audio_sample = out_reg;

    // Checks
    `PDTS_ASSERT_IMPLY(a_sample_from_last_step, aclk, aresetn,
        $rose(out_valid_reg), $past(state_reg) == pdts_pkg::ST_OUT)
    `PDTS_ASSERT_NEXT(a_key_event_one_cycle, aclk, aresetn,
        key_acc, state_reg == pdts_pkg::ST_IDLE && !$rose(out_valid_reg))
    `PDTS_ASSERT_IMPLY(a_voice_index_range, aclk, aresetn,
        state_reg != pdts_pkg::ST_IDLE, (32'(vidx_reg) < VOICE_COUNT) && (semi_reg < 4'd12))

endmodule
